// File: rtl/core/ctcg_pkg.sv
// Package with the request types, queue sizing and symbol table of the CTC greedy decoder.
`timescale 1ns / 1ps

package ctcg_pkg;

  localparam int MaxClassesDefault = 64;
  localparam int AlphabetSize      = 36;
  localparam int QueueDepth        = 4;
  localparam int QueuePtrW         = $clog2(QueueDepth);
  localparam int QueueCntW         = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic signed [15:0] score;
    logic               row_end;
    logic               sequence_end;
  } ctcg_in_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic [5:0] class_index;
    logic       is_terminator;
  } ctcg_out_t;

  // Results produced by one accepted score: count, then up to two requests in order.
  typedef struct packed {
    logic [1:0] count;
    ctcg_out_t  first;
    ctcg_out_t  second;
  } ctcg_push_t;

  // Class 1..10 map to digits, 11..36 to lower-case letters, anything else to 0.
  function automatic logic [7:0] class_symbol(input logic [5:0] cls);
    logic [7:0] sym;
    sym = 8'd0;
    if (cls >= 6'd1 && cls <= 6'd10) begin
      sym = 8'h30 + {2'b00, cls} - 8'd1;
    end else if (cls >= 6'd11 && cls <= 6'(AlphabetSize)) begin
      sym = 8'h61 + {2'b00, cls} - 8'd11;
    end
    return sym;
  endfunction

endpackage

// File: rtl/core/ctcg_row_max.sv
// Running row maximum, collapse of repeats and blanks, and result formation.
`timescale 1ns / 1ps

module ctcg_row_max import ctcg_pkg::*; #(
  parameter int MAX_CLASSES = MaxClassesDefault
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  ctcg_in_t   in_data,
  output ctcg_push_t push
);

  localparam logic [5:0] TopColumn = 6'(MAX_CLASSES - 1);

  logic signed [15:0] best_score_r, best_score_nxt;
  logic [5:0]         best_class_r, best_class_nxt;
  logic [5:0]         column_r, column_nxt;
  logic [5:0]         prev_class_r, prev_class_nxt;
  logic               first_row_r, first_row_nxt;

  logic signed [15:0] row_score;
  logic [5:0]         row_class;
  logic               row_done;
  logic               emit;
  ctcg_out_t          char_res;
  ctcg_out_t          term_res;

  always_comb begin
    // The first score of a row always takes the lead; later ones must be strictly greater.
    if (column_r == 6'd0) begin
      row_score = in_data.score;
      row_class = 6'd0;
    end else if (in_data.score > best_score_r) begin
      row_score = in_data.score;
      row_class = column_r;
    end else begin
      row_score = best_score_r;
      row_class = best_class_r;
    end

    row_done = in_data.row_end | in_data.sequence_end;
    emit     = row_done && (row_class != 6'd0) &&
               (first_row_r || (row_class != prev_class_r));

    char_res.symbol        = class_symbol(row_class);
    char_res.class_index   = row_class;
    char_res.is_terminator = 1'b0;

    term_res.symbol        = 8'd0;
    term_res.class_index   = 6'd0;
    term_res.is_terminator = 1'b1;

    push.count  = {1'b0, emit} + {1'b0, in_data.sequence_end};
    push.first  = emit ? char_res : term_res;
    push.second = term_res;

    best_score_nxt = best_score_r;
    best_class_nxt = best_class_r;
    column_nxt     = column_r;
    prev_class_nxt = prev_class_r;
    first_row_nxt  = first_row_r;

    if (accept) begin
      best_score_nxt = row_score;
      best_class_nxt = row_class;
      if (column_r < TopColumn) begin
        column_nxt = column_r + 6'd1;
      end
      if (row_done) begin
        prev_class_nxt = row_class;
        first_row_nxt  = 1'b0;
        column_nxt     = 6'd0;
      end
      if (in_data.sequence_end) begin
        best_score_nxt = '0;
        best_class_nxt = 6'd0;
        prev_class_nxt = 6'd0;
        first_row_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_score_r <= '0;
      best_class_r <= 6'd0;
      column_r     <= 6'd0;
      prev_class_r <= 6'd0;
      first_row_r  <= 1'b1;
    end else begin
      best_score_r <= best_score_nxt;
      best_class_r <= best_class_nxt;
      column_r     <= column_nxt;
      prev_class_r <= prev_class_nxt;
      first_row_r  <= first_row_nxt;
    end
  end

endmodule

// File: rtl/core/ctcg_out_queue.sv
// Small result queue that takes up to two requests a cycle and hands out one while out_stall is low.
`timescale 1ns / 1ps

module ctcg_out_queue import ctcg_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_en,
  input  ctcg_push_t push,
  output logic       room,
  output logic       out_valid,
  input  logic       out_stall,
  output ctcg_out_t  out_data
);

  ctcg_out_t              slot_r [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QueuePtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QueueCntW-1:0]   count_r, count_nxt;
  logic [QueuePtrW-1:0]   wr_ptr_2nd;
  logic [1:0]             n_push;
  logic                   pop;

  always_comb begin
    n_push     = push_en ? push.count : 2'd0;
    pop        = out_valid && !out_stall;
    wr_ptr_2nd = wr_ptr_r + QueuePtrW'(1);
    wr_ptr_nxt = wr_ptr_r + QueuePtrW'(n_push);
    rd_ptr_nxt = rd_ptr_r + QueuePtrW'(pop);
    count_nxt  = count_r + QueueCntW'(n_push) - QueueCntW'(pop);
  end

  // Room for a worst-case item (two requests) without looking at the pop.
  assign room      = (count_r <= QueueCntW'(QueueDepth - 2));
  assign out_valid = (count_r != '0);
  assign out_data  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      slot_r[wr_ptr_r] <= push.first;
    end
    if (n_push == 2'd2) begin
      slot_r[wr_ptr_2nd] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: rtl/core/ctc_greedy_decoder.sv
// Top level of the CTC greedy best-path decoder.
`timescale 1ns / 1ps
// The block takes class scores (signed Q8.8) on the in_ channel, one request per
// score, row by row; row_end closes a time step and sequence_end closes the
// sequence (and its last row). Each row's first-maximum winner is collapsed
// against the previous row's winner and the blank class, and surviving
// classes leave on the out_ channel as ASCII symbols with their class index.
// Every sequence ends with a terminator request (is_terminator set).
// Both channels use valid/stall: a request moves on a clock edge with valid
// high and stall low. A score is taken every cycle while in_stall is low;
// results of an accepted score are registered in the result queue, whose count
// drives out_valid. One score can give up to two results, held in a four-entry
// result queue; in_stall rises when fewer than two queue entries are free, so
// while the receiver stalls the queue fills and then input stops, and no result
// is lost. Sustained rate is one score per cycle as long as results drain at
// least as fast as they are produced; the queue's single read port sets the
// result rate at one per cycle. Synchronous reset empties the queue and starts
// a fresh sequence with the first-row flag set.

module ctc_greedy_decoder import ctcg_pkg::*; #(
  parameter int MAX_CLASSES = MaxClassesDefault
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ctcg_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output ctcg_out_t out_data
);

  logic       in_accept;
  logic       room;
  ctcg_push_t push;

  assign in_stall  = !room;
  assign in_accept = in_valid && room;

  ctcg_row_max #(
    .MAX_CLASSES(MAX_CLASSES)
  ) u_row_max (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_accept),
    .in_data(in_data),
    .push   (push)
  );

  ctcg_out_queue u_out_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_en  (in_accept),
    .push     (push),
    .room     (room),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule
